>>> hw/rtl/cursor_list_insert_remove_macros.svh
// Assertion macros for the cursor list block.
// Used by modules that check their own state; expects clk and arst_n in scope.
`ifndef CURSOR_LIST_INSERT_REMOVE_MACROS_SVH
`define CURSOR_LIST_INSERT_REMOVE_MACROS_SVH

// condition must hold at every edge out of reset
`define CLIR_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// consequence must hold in the cycle the antecedent is seen
`define CLIR_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// consequence must hold in the cycle after the antecedent
`define CLIR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/clir_pkg.sv
// Shared types and constants for the cursor list block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package clir_pkg;

	localparam int DEPTH       = 32;
	localparam int VALUE_WIDTH = 32;
	localparam int IDX_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W       = $clog2(DEPTH + 1);

	// beat layouts
	localparam int FUNC_W    = 3;
	localparam int FIELD_VW  = 32;
	localparam int STATUS_W  = 2;
	localparam int ECOUNT_W  = 6;
	localparam int IN_BITS   = FUNC_W + FIELD_VW;
	localparam int OUT_BITS  = STATUS_W + 1 + FIELD_VW + ECOUNT_W;
	localparam int IN_W      = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8;

	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

	typedef enum logic [2:0] {
		FN_FIRST  = 3'd0,
		FN_LAST   = 3'd1,
		FN_ADV    = 3'd2,
		FN_BACK   = 3'd3,
		FN_INSERT = 3'd4,
		FN_REMOVE = 3'd5
	} func_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_NO_CUR = 2'd1,
		ST_FULL   = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		CELL_HOLD = 2'd0,
		CELL_INS  = 2'd1,
		CELL_REM  = 2'd2
	} cell_op_t;

	// broadcast to every cell of the row
	typedef struct packed {
		cell_op_t               op;
		logic [IDX_W-1:0]       pos;
		logic [VALUE_WIDTH-1:0] value;
	} cell_cmd_t;

	typedef struct packed {
		logic [CNT_W-1:0] cursor;
		logic [CNT_W-1:0] count;
	} list_state_t;

endpackage

`default_nettype wire

>>> hw/rtl/clir_cell.sv
// One storage cell of the list row: holds one entry, shifts with its neighbors.
// Depends on clir_pkg.
`timescale 1ns / 1ps
`default_nettype none

module clir_cell import clir_pkg::*; (
	input  wire                         clk,
	input  cell_cmd_t                   cmd,
	input  wire  [IDX_W-1:0]            idx,
	input  wire  [VALUE_WIDTH-1:0]      prev_val,
	input  wire  [VALUE_WIDTH-1:0]      next_val,
	output logic [VALUE_WIDTH-1:0]      val_q
);

	always_ff @(posedge clk) begin
		case (cmd.op)
			CELL_INS: begin
				if (idx == cmd.pos) begin
					val_q <= cmd.value;
				end else if (idx > cmd.pos) begin
					val_q <= prev_val;
				end
			end
			CELL_REM: begin
				if (idx >= cmd.pos) begin
					val_q <= next_val;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

>>> hw/rtl/clir_ctrl.sv
// Cursor and count registers plus the per-operation decision logic.
// Depends on clir_pkg and cursor_list_insert_remove_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "cursor_list_insert_remove_macros.svh"

module clir_ctrl import clir_pkg::*; (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     take,
	input  wire  [FUNC_W-1:0]       func,
	input  wire  [VALUE_WIDTH-1:0]  value,
	output list_state_t             state,
	output status_t                 status,
	output cell_cmd_t               cmd
);

	logic [CNT_W-1:0] cursor_q, count_q;
	logic [CNT_W-1:0] cursor_d, count_d;
	logic             has_cur;

	assign has_cur = cursor_q < count_q;
	assign state   = '{cursor: cursor_q, count: count_q};

	always_comb begin
		cursor_d  = cursor_q;
		count_d   = count_q;
		status    = ST_OK;
		cmd.op    = CELL_HOLD;
		cmd.pos   = cursor_q[IDX_W-1:0];
		cmd.value = value;
		case (func)
			FN_FIRST: begin
				cursor_d = '0;
			end
			FN_LAST: begin
				cursor_d = (count_q != '0) ? count_q - 1'b1 : '0;
			end
			FN_ADV: begin
				if (!has_cur) begin
					status = ST_NO_CUR;
				end else begin
					cursor_d = cursor_q + 1'b1;
				end
			end
			FN_BACK: begin
				if (!has_cur) begin
					status = ST_NO_CUR;
				end else if (cursor_q == '0) begin
					cursor_d = count_q;
				end else begin
					cursor_d = cursor_q - 1'b1;
				end
			end
			FN_INSERT: begin
				if (count_q == DEPTH_C) begin
					status = ST_FULL;
				end else begin
					cursor_d = has_cur ? cursor_q + 1'b1 : '0;
					count_d  = count_q + 1'b1;
					cmd.op   = CELL_INS;
					cmd.pos  = cursor_d[IDX_W-1:0];
				end
			end
			FN_REMOVE: begin
				if (!has_cur) begin
					status = ST_NO_CUR;
				end else begin
					count_d = count_q - 1'b1;
					cmd.op  = CELL_REM;
				end
			end
			default: begin
			end
		endcase
		if (!take) begin
			cmd.op = CELL_HOLD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= '0;
			count_q  <= '0;
		end else if (take) begin
			cursor_q <= cursor_d;
			count_q  <= count_d;
		end
	end

	`CLIR_ASSERT_ALWAYS(a_count_bound, count_q <= DEPTH_C, "count above depth")
	`CLIR_ASSERT_ALWAYS(a_cursor_bound, cursor_q <= count_q, "cursor past count")
	`CLIR_ASSERT_SAME(a_full_only_at_depth, take && status == ST_FULL, count_q == DEPTH_C,
		"full reported below depth")
	`CLIR_ASSERT_NEXT(a_insert_grows, take && func == FN_INSERT && count_q != DEPTH_C,
		count_q == $past(count_q) + 1'b1, "insert did not grow the list")
	`CLIR_ASSERT_NEXT(a_idle_holds, !take, $stable(count_q) && $stable(cursor_q),
		"state moved without a beat")

endmodule

`default_nettype wire

>>> hw/rtl/cursor_list_insert_remove.sv
// Cursor list: bounded ordered list with a cursor, held in a row of shifting cells.
// An input beat updates the cursor/count and the cell row; its result is then registered.
// Throughput: one beat per cycle while the result side accepts; the whole cell row shifts in
// the same cycle as the cursor/count update, and the result register later loads from the row.
// Reset clears count, cursor and the handshake state; cell contents are not cleared.
// Depends on clir_pkg, clir_ctrl, clir_cell.
`timescale 1ns / 1ps
`default_nettype none

module cursor_list_insert_remove import clir_pkg::*; (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire  [IN_W-1:0]   s_axis_tdata,  // func[2:0], value_in[34:3], zero pad
	output logic              m_axis_tvalid,
	input  wire               m_axis_tready,
	output logic [OUT_W-1:0]  m_axis_tdata   // status[1:0], has_current[2],
	                                         // current_value[34:3], entry_count[40:35], pad
);

	logic                   take;
	logic [FUNC_W-1:0]      func;
	logic [VALUE_WIDTH-1:0] value;
	list_state_t            state;
	status_t                status;
	cell_cmd_t              cmd;

	logic                   pend_s1;
	status_t                status_s1;
	logic                   out_load;
	logic [OUT_W-1:0]       out_data_q;

	logic [VALUE_WIDTH-1:0] vals [DEPTH];
	logic                   has_cur;
	logic [FIELD_VW-1:0]    cur_val;

	assign func  = s_axis_tdata[FUNC_W-1:0];
	assign value = VALUE_WIDTH'(s_axis_tdata[FUNC_W +: FIELD_VW]);

	// the result register drains s1 whenever it is free or being taken
	assign out_load      = pend_s1 && (!m_axis_tvalid || m_axis_tready);
	assign s_axis_tready = !pend_s1 || out_load;
	assign take          = s_axis_tvalid && s_axis_tready;

	clir_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.func   (func),
		.value  (value),
		.state  (state),
		.status (status),
		.cmd    (cmd)
	);

	for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
		logic [VALUE_WIDTH-1:0] prev_v, next_v;
		if (gi == 0) begin : g_first
			assign prev_v = '0;
		end else begin : g_prev
			assign prev_v = vals[gi-1];
		end
		if (gi == DEPTH - 1) begin : g_last
			assign next_v = vals[gi];
		end else begin : g_next
			assign next_v = vals[gi+1];
		end
		clir_cell u_cell (
			.clk      (clk),
			.cmd      (cmd),
			.idx      (IDX_W'(gi)),
			.prev_val (prev_v),
			.next_val (next_v),
			.val_q    (vals[gi])
		);
	end

	// state registers already hold the s1 beat's outcome here
	assign has_cur = state.cursor < state.count;
	assign cur_val = has_cur ? FIELD_VW'(vals[state.cursor[IDX_W-1:0]]) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1       <= 1'b0;
			m_axis_tvalid <= 1'b0;
		end else begin
			if (take) begin
				pend_s1 <= 1'b1;
			end else if (out_load) begin
				pend_s1 <= 1'b0;
			end
			if (out_load) begin
				m_axis_tvalid <= 1'b1;
			end else if (m_axis_tready) begin
				m_axis_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			status_s1 <= status;
		end
		if (out_load) begin
			out_data_q <= OUT_W'({ECOUNT_W'(state.count), cur_val, has_cur, status_s1});
		end
	end

	assign m_axis_tdata = out_data_q;

endmodule

`default_nettype wire

>>> sim/cursor_list_insert_remove_chk.sv
// Scoreboard for the cursor list block: tracks the list and cursor from input beats,
// compares every result beat field by field. Depends on clir_pkg.
`timescale 1ns / 1ps

module cursor_list_insert_remove_chk import clir_pkg::*; (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              s_axis_tvalid,
	input  wire              s_axis_tready,
	input  wire [IN_W-1:0]   s_axis_tdata,   // func[2:0], value_in[34:3], pad
	input  wire              m_axis_tvalid,
	input  wire              m_axis_tready,
	input  wire [OUT_W-1:0]  m_axis_tdata,   // status[1:0], has_current[2],
	                                         // current_value[34:3], entry_count[40:35], pad
	output int               fail_count,
	output int               open_count
);

	// packed MSB first, so this matches the result beat from bit 40 down
	typedef struct packed {
		logic [ECOUNT_W-1:0] count;
		logic [FIELD_VW-1:0] value;
		logic                has_cur;
		logic [STATUS_W-1:0] status;
	} list_view_t;

	logic [VALUE_WIDTH-1:0] slot_vals [DEPTH];
	int                     list_len;
	int                     cur_idx;
	list_view_t             view_q [$];

	task automatic note_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("%0t: %s: got %0h, want %0h", $time, what, got, want);
		fail_count++;
	endtask

	// apply one operation to the tracked list, return what the block should report
	function automatic list_view_t step_list(input logic [FUNC_W-1:0] fn,
			input logic [VALUE_WIDTH-1:0] v);
		status_t    st;
		list_view_t r;
		st = ST_OK;
		case (fn)
		FN_FIRST: cur_idx = 0;
		FN_LAST:  cur_idx = (list_len > 0) ? list_len - 1 : 0;
		FN_ADV: begin
			if (cur_idx >= list_len)
				st = ST_NO_CUR;
			else
				cur_idx++;
		end
		FN_BACK: begin
			if (cur_idx >= list_len)
				st = ST_NO_CUR;
			else if (cur_idx == 0)
				cur_idx = list_len;  // off the front: no current entry
			else
				cur_idx--;
		end
		FN_INSERT: begin
			if (list_len >= DEPTH) begin
				st = ST_FULL;
			end else begin
				cur_idx = (cur_idx < list_len) ? cur_idx + 1 : 0;
				for (int i = list_len; i > cur_idx; i--)
					slot_vals[i] = slot_vals[i-1];
				slot_vals[cur_idx] = v;
				list_len++;
			end
		end
		FN_REMOVE: begin
			if (cur_idx >= list_len) begin
				st = ST_NO_CUR;
			end else begin
				for (int i = cur_idx + 1; i < list_len; i++)
					slot_vals[i-1] = slot_vals[i];
				list_len--;
			end
		end
		default: ;  // spare codes do nothing
		endcase
		r.status  = st;
		r.has_cur = (cur_idx < list_len);
		r.value   = r.has_cur ? FIELD_VW'(slot_vals[cur_idx]) : '0;
		r.count   = ECOUNT_W'(list_len);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		list_view_t got;
		list_view_t want;
		if (!arst_n) begin
			list_len   = 0;
			cur_idx    = 0;
			open_count = 0;
			view_q.delete();
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = list_view_t'(m_axis_tdata[OUT_BITS-1:0]);
				if (view_q.size() == 0) begin
					note_mismatch("result beat with nothing pending", got, '0);
				end else begin
					want = view_q.pop_front();
					if (got.status !== want.status)
						note_mismatch("status", got.status, want.status);
					if (got.has_cur !== want.has_cur)
						note_mismatch("has_current", got.has_cur, want.has_cur);
					if (got.value !== want.value)
						note_mismatch("current_value", got.value, want.value);
					if (got.count !== want.count)
						note_mismatch("entry_count", got.count, want.count);
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				view_q.push_back(step_list(s_axis_tdata[FUNC_W-1:0],
					s_axis_tdata[FUNC_W +: FIELD_VW]));
			open_count = view_q.size();
		end
	end

endmodule

>>> sim/cursor_list_insert_remove_tb.sv
// Top of the cursor list testbench: clock, reset, stimulus and verdict.
// Depends on clir_pkg, cursor_list_insert_remove and cursor_list_insert_remove_chk.
`timescale 1ns / 1ps

module cursor_list_insert_remove_tb;
	import clir_pkg::*;

	localparam logic [FUNC_W-1:0] FN_SPARE6 = 3'd6;
	localparam logic [FUNC_W-1:0] FN_SPARE7 = 3'd7;
	localparam int                RAND_BEATS = 925;
	localparam int                HOLD_AFTER = 300;
	localparam int                HOLD_LEN   = 150;

	typedef enum {EP_FILL, EP_DRAIN, EP_MIXED} episode_t;

	logic             clk           = 1'b0;
	logic             arst_n        = 1'b0;
	logic             s_axis_tvalid = 1'b0;
	logic [IN_W-1:0]  s_axis_tdata  = '0;
	logic             m_axis_tready = 1'b0;
	wire              s_axis_tready;
	wire              m_axis_tvalid;
	wire [OUT_W-1:0]  m_axis_tdata;

	int fail_count;
	int open_count;
	int beats_in = 0;
	bit no_gaps  = 1'b0;

	cursor_list_insert_remove i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	cursor_list_insert_remove_chk i_chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.fail_count    (fail_count),
		.open_count    (open_count)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 0;
	end

	initial begin
		#5_000_000;
		$display("cursor_list_insert_remove verification failed");
		$finish;
	end

	// valid stays up across back-to-back beats; it only drops for a gap
	task automatic send_beat(input logic [FUNC_W-1:0] fn, input logic [FIELD_VW-1:0] v);
		int r;
		int gap;
		s_axis_tdata  <= IN_W'({v, fn});
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		beats_in++;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 55)
			gap = 0;
		else if (r < 92)
			gap = $urandom_range(1, 3);
		else
			gap = $urandom_range(8, 30);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// result side: random stalls, plus one long hold-off to back up the block
	initial begin
		int  r;
		bit  held;
		held = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (!held && beats_in >= HOLD_AFTER) begin
				held = 1'b1;
				m_axis_tready <= 1'b0;
				repeat (HOLD_LEN) @(posedge clk);
			end
			r = $urandom_range(0, 99);
			if (r < 60) begin
				m_axis_tready <= 1'b1;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end else if (r < 95) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 3)) @(posedge clk);
			end else begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(10, 40)) @(posedge clk);
			end
		end
	end

	initial begin
		episode_t               ep;
		int                     span;
		int                     r;
		int                     rv;
		logic [FUNC_W-1:0]      fn;
		logic [FIELD_VW-1:0]    v;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list corner cases
		send_beat(FN_FIRST, '0);
		send_beat(FN_LAST, '0);
		send_beat(FN_ADV, '0);
		send_beat(FN_BACK, '0);
		send_beat(FN_REMOVE, '1);
		send_beat(FN_SPARE6, '1);
		send_beat(FN_SPARE7, '0);
		// build a short list, walk off the end, insert at front with no current
		send_beat(FN_INSERT, 32'h0000_0000);
		send_beat(FN_INSERT, 32'hFFFF_FFFF);
		send_beat(FN_INSERT, 32'h5555_5555);
		send_beat(FN_ADV, '0);
		send_beat(FN_ADV, '0);
		send_beat(FN_INSERT, 32'hAAAA_AAAA);
		send_beat(FN_BACK, '0);
		send_beat(FN_LAST, '0);
		send_beat(FN_REMOVE, '0);
		send_beat(FN_REMOVE, '0);
		send_beat(FN_FIRST, '0);
		send_beat(FN_ADV, '0);
		send_beat(FN_REMOVE, '0);
		send_beat(FN_BACK, '0);
		send_beat(FN_SPARE6, 32'h8000_0001);
		send_beat(FN_FIRST, '0);

		// episodes: fill toward full, drain toward empty, or anything goes
		while (beats_in < RAND_BEATS) begin
			ep      = episode_t'($urandom_range(0, 2));
			no_gaps = ($urandom_range(0, 4) == 0);
			span    = $urandom_range(20, 50);
			repeat (span) begin
				r = $urandom_range(0, 99);
				case (ep)
				EP_FILL: begin
					if (r < 85)
						fn = FN_INSERT;
					else
						fn = FUNC_W'($urandom_range(FN_FIRST, FN_BACK));
				end
				EP_DRAIN: begin
					if (r < 65)
						fn = FN_REMOVE;
					else if (r < 80)
						fn = FN_FIRST;
					else if (r < 88)
						fn = FN_LAST;
					else
						fn = FN_BACK;
				end
				default: begin
					if (r < 3)
						fn = $urandom_range(0, 1) ? FN_SPARE6 : FN_SPARE7;
					else
						fn = FUNC_W'($urandom_range(FN_FIRST, FN_REMOVE));
				end
				endcase
				rv = $urandom_range(0, 9);
				if (rv == 0)
					v = '0;
				else if (rv == 1)
					v = '1;
				else
					v = $urandom();
				send_beat(fn, v);
			end
		end
		s_axis_tvalid <= 1'b0;

		@(negedge clk);
		wait (open_count == 0);
		repeat (20) @(posedge clk);
		if (fail_count == 0 && open_count == 0)
			$display("cursor_list_insert_remove verification clean");
		else
			$display("cursor_list_insert_remove verification failed");
		$finish;
	end

endmodule

>>> cursor_list_insert_remove.f
+incdir+hw/rtl
hw/rtl/clir_pkg.sv
hw/rtl/clir_cell.sv
hw/rtl/clir_ctrl.sv
hw/rtl/cursor_list_insert_remove.sv
sim/cursor_list_insert_remove_chk.sv
sim/cursor_list_insert_remove_tb.sv
